// ===== design/telemetry_frame_serializer_top_assert.svh =====
// Assertion macros for the telemetry frame serializer.
// Setting ASSERT_OFF turns every check into an empty statement.
`ifndef TELEMETRY_FRAME_SERIALIZER_TOP_ASSERT_SVH
`define TELEMETRY_FRAME_SERIALIZER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define TFS_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

`define TFS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`else

`define TFS_ASSERT_SAME(label, clk, rst, cond, prop, msg)

`define TFS_ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

// ===== design/tfs_pkg.sv =====
`default_nettype none

package tfs_pkg;

  localparam int unsigned PAYLOAD_MAX_BYTES = 14;
  localparam int unsigned PAYLOAD_W = PAYLOAD_MAX_BYTES * 8;

  localparam logic [7:0] HEADER_BYTE = 8'hAA;
  localparam logic [7:0] DEST_RESET = 8'hFF;

  // Frame type codes carried on the opcode field.
  localparam logic [2:0] OP_CUSTOM = 3'd0;
  localparam logic [2:0] OP_IMU = 3'd1;
  localparam logic [2:0] OP_BARO = 3'd2;
  localparam logic [2:0] OP_EULER = 3'd3;
  localparam logic [2:0] OP_QUAT = 3'd4;
  localparam logic [2:0] OP_ALT = 3'd5;

  // Command bytes sent on the wire.
  localparam logic [7:0] CMD_CUSTOM = 8'hF1;
  localparam logic [7:0] CMD_IMU = 8'h01;
  localparam logic [7:0] CMD_BARO = 8'h02;
  localparam logic [7:0] CMD_EULER = 8'h03;
  localparam logic [7:0] CMD_QUAT = 8'h04;
  localparam logic [7:0] CMD_ALT = 8'h05;

  // Payload lengths in bytes.
  localparam logic [3:0] LEN_CUSTOM = 4'd8;
  localparam logic [3:0] LEN_IMU = 4'd13;
  localparam logic [3:0] LEN_BARO = 4'd14;
  localparam logic [3:0] LEN_EULER = 4'd7;
  localparam logic [3:0] LEN_QUAT = 4'd9;
  localparam logic [3:0] LEN_ALT = 4'd9;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value_0;
    logic signed [31:0] value_1;
    logic signed [31:0] value_2;
    logic signed [31:0] value_3;
    logic signed [31:0] value_4;
    logic signed [31:0] value_5;
    logic [7:0]         status_0;
    logic [7:0]         status_1;
  } request_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } result_t;

  typedef logic [PAYLOAD_W-1:0] payload_t;

  function automatic logic op_valid(input logic [2:0] op);
    return (op == OP_CUSTOM) || (op == OP_IMU) || (op == OP_BARO) ||
           (op == OP_EULER) || (op == OP_QUAT) || (op == OP_ALT);
  endfunction

  function automatic logic [7:0] frame_cmd(input logic [2:0] op);
    logic [7:0] c;
    unique case (op)
      OP_CUSTOM: c = CMD_CUSTOM;
      OP_IMU:    c = CMD_IMU;
      OP_BARO:   c = CMD_BARO;
      OP_EULER:  c = CMD_EULER;
      OP_QUAT:   c = CMD_QUAT;
      OP_ALT:    c = CMD_ALT;
      default:   c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] payload_len(input logic [2:0] op);
    logic [3:0] n;
    unique case (op)
      OP_CUSTOM: n = LEN_CUSTOM;
      OP_IMU:    n = LEN_IMU;
      OP_BARO:   n = LEN_BARO;
      OP_EULER:  n = LEN_EULER;
      OP_QUAT:   n = LEN_QUAT;
      OP_ALT:    n = LEN_ALT;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

  // Lays the payload out so that byte 0 of the frame payload sits in bits 7:0.
  function automatic payload_t pack_payload(input request_t r);
    payload_t p;
    unique case (r.opcode)
      OP_CUSTOM: p = {48'd0, r.value_2, r.value_1[15:0], r.value_0[15:0]};
      OP_IMU:    p = {8'd0, r.status_0, r.value_5[15:0], r.value_4[15:0],
                      r.value_3[15:0], r.value_2[15:0], r.value_1[15:0],
                      r.value_0[15:0]};
      OP_BARO:   p = {r.status_1, r.status_0, r.value_4[15:0], r.value_3,
                      r.value_2[15:0], r.value_1[15:0], r.value_0[15:0]};
      OP_EULER:  p = {56'd0, r.status_0, r.value_2[15:0], r.value_1[15:0],
                      r.value_0[15:0]};
      OP_QUAT:   p = {40'd0, r.status_0, r.value_3[15:0], r.value_2[15:0],
                      r.value_1[15:0], r.value_0[15:0]};
      OP_ALT:    p = {40'd0, r.status_0, r.value_1, r.value_0};
      default:   p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== design/tfs_shift.sv =====
`default_nettype none

// Payload shift register: loaded in parallel, emptied one byte per cycle while shift is high.
module tfs_shift (
  input  wire logic              clk,
  input  wire logic              load,
  input  wire tfs_pkg::payload_t load_data,
  input  wire logic              shift,
  output logic [7:0]             data_byte
);
  import tfs_pkg::*;

  payload_t sreg;

  always_ff @(posedge clk) begin
    if (load) begin
      sreg <= load_data;
    end else if (shift) begin
      sreg <= {8'd0, sreg[PAYLOAD_W-1:8]};
    end
  end

  assign data_byte = sreg[7:0];

endmodule

`default_nettype wire

// ===== design/tfs_check.sv =====
`default_nettype none

// Running sum and sum of running sums, one byte per cycle while update is high.
module tfs_check (
  input  wire logic       clk,
  input  wire logic       clear,
  input  wire logic       update,
  input  wire logic [7:0] data_byte,
  output logic [7:0]      sum_check,
  output logic [7:0]      add_check
);
  import tfs_pkg::*;

  logic [7:0] sum_next;

  assign sum_next = sum_check + data_byte;

  always_ff @(posedge clk) begin
    if (clear) begin
      sum_check <= 8'd0;
      add_check <= 8'd0;
    end else if (update) begin
      sum_check <= sum_next;
      add_check <= add_check + sum_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/telemetry_frame_serializer_top.sv =====
// Telemetry frame serializer: one request in, one frame out, a byte per cycle.
// The header byte is registered onto the result port after the sequencer enters the
// header position. Frames are 13 to 20 bytes long; busy falls in the cycle that
// produces the add-check byte, so frames run gap-free. Results cannot be stalled.
// Reset clears the sequencer and strobe and sets dest_address to 0xFF; frame
// types 6 and 7 are accepted and produce nothing.
`default_nettype none

`include "telemetry_frame_serializer_top_assert.svh"

module telemetry_frame_serializer_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire tfs_pkg::request_t request,
  output tfs_pkg::result_t       result,
  output logic                   result_strobe,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_data
);
  import tfs_pkg::*;

  // Fixed byte positions at the head of every frame.
  localparam logic [4:0] POS_HEADER = 5'd0;
  localparam logic [4:0] POS_DEST = 5'd1;
  localparam logic [4:0] POS_CMD = 5'd2;
  localparam logic [4:0] POS_LEN = 5'd3;
  localparam logic [4:0] POS_PAYLOAD = 5'd4;

  // Sequencer registers. The index counts frame bytes; last_idx marks the
  // add-check byte, and the sum-check byte sits one place before it.
  logic       active;
  logic [4:0] idx;
  logic [4:0] last_idx;
  logic [3:0] pay_len;
  logic [7:0] cmd_byte;
  logic [7:0] dest_address;

  logic       accept;
  logic       load;
  logic [4:0] sum_idx;
  logic       in_body;
  logic       shift_en;
  logic [7:0] pay_byte;
  logic [7:0] sum_check;
  logic [7:0] add_check;
  logic [7:0] byte_next;

  // The block can take the next request while the add-check byte of the
  // current frame is being registered.
  assign busy = active && (idx != last_idx);
  assign accept = start && !busy;
  assign load = accept && op_valid(request.opcode);

  // Configuration transfers are taken whenever no frame is in flight.
  assign cfg_ready = !active;

  assign sum_idx = last_idx - 5'd1;
  assign in_body = active && (idx < sum_idx);
  assign shift_en = in_body && (idx >= POS_PAYLOAD);

  tfs_shift u_shift (
    .clk       (clk),
    .load      (load),
    .load_data (pack_payload(request)),
    .shift     (shift_en),
    .data_byte (pay_byte)
  );

  // Both check bytes cover header through the end of the payload.
  tfs_check u_check (
    .clk       (clk),
    .clear     (load),
    .update    (in_body),
    .data_byte (byte_next),
    .sum_check (sum_check),
    .add_check (add_check)
  );

  // Byte selection for the current frame position.
  always_comb begin
    priority if (idx == POS_HEADER) begin
      byte_next = HEADER_BYTE;
    end else if (idx == POS_DEST) begin
      byte_next = dest_address;
    end else if (idx == POS_CMD) begin
      byte_next = cmd_byte;
    end else if (idx == POS_LEN) begin
      byte_next = {4'd0, pay_len};
    end else if (idx < sum_idx) begin
      byte_next = pay_byte;
    end else if (idx == sum_idx) begin
      byte_next = sum_check;
    end else begin
      byte_next = add_check;
    end
  end

  // Sequencer, output register and the destination register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx <= POS_HEADER;
      last_idx <= 5'd0;
      result_strobe <= 1'b0;
      dest_address <= DEST_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dest_address <= cfg_data;
      end
      result_strobe <= active;
      if (load) begin
        active <= 1'b1;
        idx <= POS_HEADER;
        last_idx <= {1'b0, payload_len(request.opcode)} + 5'd5;
      end else if (active) begin
        if (idx == last_idx) begin
          active <= 1'b0;
        end else begin
          idx <= idx + 5'd1;
        end
      end
    end
  end

  // Payload-side registers need no reset; the strobe qualifies them.
  always_ff @(posedge clk) begin
    result.frame_byte <= byte_next;
    result.last_byte <= active && (idx == last_idx);
    if (load) begin
      pay_len <= payload_len(request.opcode);
      cmd_byte <= frame_cmd(request.opcode);
    end
  end

  // A frame always opens with the header: the sequencer enters the header
  // position, and the byte is registered onto the ports after it.
  `TFS_ASSERT_NEXT(a_header_first, clk, rst, load,
    1'b1 ##1 (result_strobe && (result.frame_byte == HEADER_BYTE) && !result.last_byte),
    "frame did not start with the header byte")

  // The add-check position produces the end-of-frame mark.
  `TFS_ASSERT_NEXT(a_last_marked, clk, rst, active && (idx == last_idx),
    result_strobe && result.last_byte, "add-check byte not marked as last")

  // The end-of-frame mark never appears without a strobe.
  `TFS_ASSERT_SAME(a_last_strobed, clk, rst, result.last_byte,
    result_strobe, "last_byte raised outside a result transfer")

endmodule

`default_nettype wire
